// File: design/astc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// astc_pkg
// Shared types and constants of the analog stick and trigger conditioner.
// ----------------------------------------------------------------------------
package astc_pkg;

   localparam int CHAN_W   = 2;
   localparam int SMP_W    = 12;
   localparam int LEVEL_W  = 12;
   localparam int STICK_W  = 8;
   localparam int PULL_W   = 8;
   localparam int ALPHA_W  = 9;
   localparam int FRAC_W   = 8;
   localparam int CAL_W    = 64;
   localparam int FIELD_W  = 16;
   localparam int NUM_CAL  = 4;
   localparam int DATA_W   = 64;
   localparam int ADDR_W   = 6;
   localparam int IDX_W    = 3;
   localparam int IDX_LSB  = 3;

   // iterative divider: numerator, divisor and quotient widths
   localparam int NUM_W    = 26;
   localparam int DEN_W    = 17;
   localparam int QUOT_W   = 8;
   localparam int STEP_W   = 4;
   localparam logic [STEP_W-1:0] STEP_TOP = 4'd8;

   localparam logic [CHAN_W-1:0]  INV_CH    = 2'd1;
   localparam logic [CHAN_W-1:0]  TRIG_CH   = 2'd2;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd205;
   localparam logic [FRAC_W:0]    ROUND_HALF  = 9'd128;
   localparam logic [QUOT_W-1:0]  STICK_MAX   = 8'd127;
   localparam logic [QUOT_W-1:0]  PULL_MAX    = 8'd255;

   localparam logic [CAL_W-1:0] CAL_STICK_RESET = 64'h0064_0FFF_0000_0800;
   localparam logic [CAL_W-1:0] CAL_TRIG_RESET  = 64'h0032_0FFF_0000_0000;

   localparam logic [IDX_W-1:0] REG_ALPHA = 3'd0;
   localparam logic [IDX_W-1:0] REG_CAL0  = 3'd1;
   localparam logic [IDX_W-1:0] REG_CAL1  = 3'd2;
   localparam logic [IDX_W-1:0] REG_CAL2  = 3'd3;
   localparam logic [IDX_W-1:0] REG_CAL3  = 3'd4;

   typedef struct packed {
      logic [CHAN_W-1:0] chan;
      logic [SMP_W-1:0]  sample;
   } astc_req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]         out_chan;
      logic [LEVEL_W-1:0]        level;
      logic signed [STICK_W-1:0] stick_pos;
      logic [PULL_W-1:0]         pull;
      logic                      dead;
   } astc_rsp_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] numer;
      logic [DEN_W-1:0] denom;
   } astc_div_cmd_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } astc_div_res_type;

endpackage

// File: design/astc_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// astc_divider
// Restoring divider with a saturating 8-bit quotient: one compare and
// subtract per cycle, first step detects a quotient of 256 or more.
// ----------------------------------------------------------------------------
module astc_divider
   import astc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  astc_div_cmd_type cmd,
   output astc_div_res_type res
);

   logic                busy_ff;
   logic                done_ff;
   logic                sat_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [NUM_W-1:0]    rem_ff;
   logic [DEN_W-1:0]    den_ff;
   logic [QUOT_W-1:0]   quot_ff;
   logic [NUM_W-1:0]    den_shift;
   logic [NUM_W:0]      trial;

   assign den_shift = NUM_W'(den_ff) << step_ff;
   assign trial     = {1'b0, rem_ff} - {1'b0, den_shift};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_TOP;
            rem_ff  <= cmd.numer;
            den_ff  <= cmd.denom;
            quot_ff <= '0;
            sat_ff  <= 1'b0;
         end else if (busy_ff) begin
            if (!trial[NUM_W]) begin
               rem_ff <= trial[NUM_W-1:0];
               if (step_ff == STEP_TOP) begin
                  sat_ff <= 1'b1;
               end else begin
                  quot_ff[step_ff[IDX_W-1:0]] <= 1'b1;
               end
            end
            if (step_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff - 1'b1;
            end
         end
      end
   end

   assign res.done = done_ff;
   assign res.quot = sat_ff ? PULL_MAX : quot_ff;

endmodule

// File: design/analog_stick_trigger_conditioner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// analog_stick_trigger_conditioner
// Per-channel EMA filter of ADC samples, mapped to stick or trigger values.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one beat per ADC sample (channel and raw value). rsp_* gives
//   one beat per sample: filtered level, stick value with deadzone flag, or
//   trigger pull. A channel at or above CHANNELS is taken and dropped.
//   Registers sit on the APB-style port at 8-byte spacing: alpha, then the
//   four calibration words.
//   One sample is worked on at a time. A shared multiplier forms the two EMA
//   products in turn, then a compare/subtract divider resolves the scaled
//   value. req_ready rises as the result enters the output register, so a
//   new sample is taken only once the previous one is finished.
//   If the receiver stalls, the finished result waits in the sequencer until
//   the output register frees; no further sample is taken meanwhile.
//   Reset restores the register defaults and marks every channel unseeded:
//   the next sample of a channel seeds its average directly.
// ----------------------------------------------------------------------------
module analog_stick_trigger_conditioner
   import astc_pkg::*;
#(
   parameter int CHANNELS    = 4,
   parameter int SAMPLE_BITS = 12
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  astc_req_type      req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output astc_rsp_type      rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   localparam int CH_W  = $clog2(CHANNELS);
   localparam int AVG_W = SAMPLE_BITS + FRAC_W;
   localparam int MUL_W = ALPHA_W + AVG_W;
   localparam int SW    = 19;

   typedef enum logic [2:0] {
      S_IDLE, S_MUL_NEW, S_MUL_OLD, S_SUM, S_PREP, S_DECIDE, S_DIV, S_FIN
   } state_type;

   state_type              state_ff;
   logic [CHAN_W-1:0]      chan_ff;
   logic [SAMPLE_BITS-1:0] smp_ff;
   logic [SAMPLE_BITS-1:0] level_ff;
   logic [AVG_W-1:0]       avg_ff [CHANNELS];
   logic [CHANNELS-1:0]    seeded_ff;
   logic [MUL_W-1:0]       mul_ff;
   logic [MUL_W-1:0]       term_ff;
   logic signed [SW-1:0]   offs_ff;
   logic signed [SW-1:0]   rng_pos_ff;
   logic signed [SW-1:0]   rng_neg_ff;
   logic signed [SW-1:0]   trig_rng_ff;
   logic signed [SW-1:0]   trig_diff_ff;
   logic signed [SW-1:0]   dz_ff;
   logic                   neg_ff;
   logic signed [STICK_W-1:0] res_stick_ff;
   logic [PULL_W-1:0]      res_pull_ff;
   logic                   res_dead_ff;
   logic                   rsp_valid_ff;
   astc_rsp_type           rsp_ff;

   logic [ALPHA_W-1:0]     alpha_ff;
   logic [CAL_W-1:0]       cal_ff [NUM_CAL];

   logic [CH_W-1:0]        idx;
   logic                   chan_ok;
   logic [ALPHA_W-1:0]     alpha_eff;
   logic [ALPHA_W-1:0]     mul_a;
   logic [AVG_W-1:0]       mul_b;
   logic [MUL_W-1:0]       mul_p;
   logic [MUL_W-1:0]       avg_sum;
   logic [AVG_W-1:0]       avg_in;
   logic [CAL_W-1:0]       cal_cur;
   logic signed [SW-1:0]   lvl_s;
   logic signed [SW-1:0]   cen_s;
   logic signed [SW-1:0]   min_s;
   logic signed [SW-1:0]   max_s;
   logic signed [SW-1:0]   dz_s;
   logic signed [SW-1:0]   diff_s;
   logic signed [SW-1:0]   mag;
   logic signed [SW-1:0]   excess;
   logic signed [SW-1:0]   stick_rng;
   logic                   is_trig;
   logic                   in_dead;
   logic                   go_trig;
   logic                   go_stick;
   logic [NUM_W-1:0]       stick_num;
   logic [NUM_W-1:0]       trig_num;
   logic [QUOT_W-1:0]      stick_mag;
   astc_div_cmd_type       div_cmd;
   astc_div_res_type       div_res;

   // ---- register file ----
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff  <= ALPHA_RESET;
         cal_ff[0] <= CAL_STICK_RESET;
         cal_ff[1] <= CAL_STICK_RESET;
         cal_ff[2] <= CAL_TRIG_RESET;
         cal_ff[3] <= CAL_STICK_RESET;
      end else if (psel && penable && pwrite) begin
         case (paddr[ADDR_W-1:IDX_LSB])
            REG_ALPHA: alpha_ff  <= pwdata[ALPHA_W-1:0];
            REG_CAL0:  cal_ff[0] <= pwdata;
            REG_CAL1:  cal_ff[1] <= pwdata;
            REG_CAL2:  cal_ff[2] <= pwdata;
            REG_CAL3:  cal_ff[3] <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[ADDR_W-1:IDX_LSB])
         REG_ALPHA: prdata = DATA_W'(alpha_ff);
         REG_CAL0:  prdata = cal_ff[0];
         REG_CAL1:  prdata = cal_ff[1];
         REG_CAL2:  prdata = cal_ff[2];
         REG_CAL3:  prdata = cal_ff[3];
         default:   prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   // ---- filter datapath ----
   assign idx       = CH_W'(chan_ff);
   assign chan_ok   = int'(req_data.chan) < CHANNELS;
   assign alpha_eff = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
   assign mul_a     = (state_ff == S_MUL_NEW) ? alpha_eff : ALPHA_ONE - alpha_eff;
   assign mul_b     = (state_ff == S_MUL_NEW) ? AVG_W'(smp_ff) : avg_ff[idx];
   assign mul_p     = MUL_W'(mul_a) * MUL_W'(mul_b);
   assign avg_sum   = term_ff + ((mul_ff + MUL_W'(ROUND_HALF)) >> FRAC_W);
   assign avg_in    = avg_sum[AVG_W-1:0];

   // ---- mapping datapath ----
   assign cal_cur = cal_ff[chan_ff];
   assign lvl_s   = $signed(SW'(level_ff));
   assign cen_s   = SW'($signed(cal_cur[FIELD_W-1:0]));
   assign min_s   = SW'($signed(cal_cur[2*FIELD_W-1:FIELD_W]));
   assign max_s   = SW'($signed(cal_cur[3*FIELD_W-1:2*FIELD_W]));
   assign dz_s    = SW'($signed(cal_cur[4*FIELD_W-1:3*FIELD_W]));
   assign diff_s  = lvl_s - cen_s;

   assign is_trig   = (chan_ff == TRIG_CH);
   assign mag       = (offs_ff < 0) ? -offs_ff : offs_ff;
   assign in_dead   = (mag <= dz_ff);
   assign excess    = mag - dz_ff;
   assign stick_rng = (offs_ff > 0) ? rng_pos_ff : rng_neg_ff;
   assign go_trig   = (trig_rng_ff > 0) && (trig_diff_ff > 0);
   assign go_stick  = !in_dead && (stick_rng > 0);
   assign stick_num = NUM_W'(excess[DEN_W-1:0]) * NUM_W'(STICK_MAX);
   assign trig_num  = NUM_W'(trig_diff_ff[DEN_W-1:0]) * NUM_W'(PULL_MAX);

   assign div_cmd.start = (state_ff == S_DECIDE) && (is_trig ? go_trig : go_stick);
   assign div_cmd.numer = is_trig ? trig_num : stick_num;
   assign div_cmd.denom = is_trig ? trig_rng_ff[DEN_W-1:0] : stick_rng[DEN_W-1:0];

   assign stick_mag = (div_res.quot > STICK_MAX) ? STICK_MAX : div_res.quot;

   astc_divider u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   // ---- sequencer ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seeded_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != S_FIN)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  chan_ff <= req_data.chan;
                  smp_ff  <= SAMPLE_BITS'(req_data.sample);
                  if (chan_ok) begin
                     state_ff <= S_MUL_NEW;
                  end
               end
            end
            S_MUL_NEW: begin
               if (seeded_ff[idx]) begin
                  mul_ff   <= mul_p;
                  state_ff <= S_MUL_OLD;
               end else begin
                  avg_ff[idx]    <= {smp_ff, FRAC_W'(0)};
                  seeded_ff[idx] <= 1'b1;
                  level_ff       <= smp_ff;
                  state_ff       <= S_PREP;
               end
            end
            S_MUL_OLD: begin
               term_ff  <= mul_ff;
               mul_ff   <= mul_p;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               avg_ff[idx] <= avg_in;
               level_ff    <= avg_in[AVG_W-1:FRAC_W];
               state_ff    <= S_PREP;
            end
            S_PREP: begin
               offs_ff      <= (chan_ff == INV_CH) ? -diff_s : diff_s;
               rng_pos_ff   <= max_s - cen_s - dz_s;
               rng_neg_ff   <= cen_s - dz_s - min_s;
               trig_rng_ff  <= max_s - min_s;
               trig_diff_ff <= max_s - lvl_s;
               dz_ff        <= dz_s;
               state_ff     <= S_DECIDE;
            end
            S_DECIDE: begin
               neg_ff       <= !(offs_ff > 0);
               res_stick_ff <= '0;
               res_pull_ff  <= '0;
               res_dead_ff  <= !is_trig && in_dead;
               state_ff     <= div_cmd.start ? S_DIV : S_FIN;
            end
            S_DIV: begin
               if (div_res.done) begin
                  if (is_trig) begin
                     res_pull_ff <= div_res.quot;
                  end else begin
                     res_stick_ff <= neg_ff ? $signed(8'd0 - stick_mag) : $signed(stick_mag);
                  end
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff.out_chan  <= chan_ff;
                  rsp_ff.level     <= LEVEL_W'(level_ff);
                  rsp_ff.stick_pos <= res_stick_ff;
                  rsp_ff.pull      <= res_pull_ff;
                  rsp_ff.dead      <= res_dead_ff;
                  rsp_valid_ff     <= 1'b1;
                  state_ff         <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: bench/analog_stick_trigger_conditioner_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// analog_stick_trigger_conditioner_test
// Self-checking bench for the stick and trigger conditioner. A table of
// directed samples and register writes covers seeding, alpha extremes, empty
// ranges and negative deadzones. Random phases with fresh calibration follow.
// Each accepted sample runs through a local EMA and mapping model; results
// are compared field by field. Sender bursts and receiver stalls vary.
// ----------------------------------------------------------------------------
module analog_stick_trigger_conditioner_test;
   import astc_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 225;
   localparam int DIR_ROWS        = 32;

   // indexes with no register behind them
   localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd5;
   localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

   typedef struct {
      bit                is_write;
      logic [IDX_W-1:0]  idx;
      logic [DATA_W-1:0] wdata;
      astc_req_type      item;
      bit                pinned;
      astc_rsp_type      want;
   } stim_row_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   astc_req_type      req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   astc_rsp_type      rsp_data;
   logic              psel      = 1'b0;
   logic              penable   = 1'b0;
   logic              pwrite    = 1'b0;
   logic [ADDR_W-1:0] paddr     = '0;
   logic [DATA_W-1:0] pwdata    = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   // model state and registers
   logic [ALPHA_W-1:0]      alpha_reg = ALPHA_RESET;
   logic [CAL_W-1:0]        cal_word [NUM_CAL] = '{CAL_STICK_RESET, CAL_STICK_RESET,
                                                   CAL_TRIG_RESET, CAL_STICK_RESET};
   logic [SMP_W+FRAC_W-1:0] ema_acc  [4] = '{default: '0};
   bit                      seeded   [4] = '{default: 1'b0};

   astc_rsp_type pending_rsp [$];
   int           mismatches = 0;
   int           cycles     = 0;
   int           burst_left = 0;
   bit           pin_valid  = 1'b0;
   astc_rsp_type pin_rsp    = '0;
   stim_row_type directed [DIR_ROWS];

   analog_stick_trigger_conditioner i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint cal_field(logic [CAL_W-1:0] word, int pos);
      logic signed [FIELD_W-1:0] f;
      f = word[pos +: FIELD_W];
      return longint'(f);
   endfunction

   // EMA update of the channel, then stick or trigger mapping of its level
   function automatic astc_rsp_type filter_and_map(astc_req_type item);
      astc_rsp_type r;
      longint a, acc, lvl, ctr, lo, hi, dz, rng, num, q, off, mag;
      int ch;
      ch = int'(item.chan);
      a  = (alpha_reg > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha_reg);
      if (!seeded[ch]) begin
         ema_acc[ch] = {item.sample, {FRAC_W{1'b0}}};
         seeded[ch]  = 1'b1;
      end else begin
         acc = a * (longint'(item.sample) << FRAC_W) + (256 - a) * longint'(ema_acc[ch])
               + 128;
         ema_acc[ch] = acc[SMP_W+2*FRAC_W-1:FRAC_W];
      end
      lvl = longint'(ema_acc[ch] >> FRAC_W);
      ctr = cal_field(cal_word[ch], 0);
      lo  = cal_field(cal_word[ch], 16);
      hi  = cal_field(cal_word[ch], 32);
      dz  = cal_field(cal_word[ch], 48);
      r = '0;
      r.out_chan = item.chan;
      r.level    = lvl[LEVEL_W-1:0];
      if (item.chan == TRIG_CH) begin
         rng = hi - lo;
         num = (hi - lvl) * 255;
         if (rng > 0 && num > 0) begin
            q = num / rng;
            if (q > 255) q = 255;
            r.pull = q[PULL_W-1:0];
         end
      end else begin
         off = lvl - ctr;
         if (item.chan == INV_CH) off = -off;
         mag = (off < 0) ? -off : off;
         if (mag <= dz) begin
            r.dead = 1'b1;
         end else begin
            if (off > 0) rng = hi - (ctr + dz);
            else rng = (ctr - dz) - lo;
            if (rng > 0) begin
               q = ((mag - dz) * 127) / rng;
               if (q > 127) q = 127;
               if (q < 0) q = 0;
               if (off <= 0) q = -q;
               r.stick_pos = q[STICK_W-1:0];
            end
         end
      end
      return r;
   endfunction

   function automatic stim_row_type smp(int chan, int sample);
      stim_row_type row;
      row = '{default: '0};
      row.item.chan   = CHAN_W'(chan);
      row.item.sample = SMP_W'(sample);
      return row;
   endfunction

   function automatic stim_row_type pin(int chan, int sample, int lvl, int stick, int pull,
                                        bit dead);
      stim_row_type row;
      row = smp(chan, sample);
      row.pinned         = 1'b1;
      row.want.out_chan  = CHAN_W'(chan);
      row.want.level     = LEVEL_W'(lvl);
      row.want.stick_pos = STICK_W'(stick);
      row.want.pull      = PULL_W'(pull);
      row.want.dead      = dead;
      return row;
   endfunction

   function automatic stim_row_type wr(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
      stim_row_type row;
      row = '{default: '0};
      row.is_write = 1'b1;
      row.idx      = idx;
      row.wdata    = value;
      return row;
   endfunction

   function automatic logic [CAL_W-1:0] random_cal(bit trigger);
      logic [FIELD_W-1:0] c, lo, hi, dz;
      int pick;
      pick = $urandom_range(0, 9);
      c  = FIELD_W'($urandom_range(0, 4095));
      lo = FIELD_W'($urandom_range(0, c));
      hi = FIELD_W'($urandom_range(c, 4095));
      dz = FIELD_W'($urandom_range(0, 400));
      if (trigger) begin
         lo = FIELD_W'($urandom_range(0, 2047));
         hi = FIELD_W'($urandom_range(1024, 4095));
      end
      if (pick == 1) begin
         dz = FIELD_W'($urandom_range(1, 300));
         dz = -dz;
      end
      if (pick == 2) hi = c;
      if (pick == 0) return {$urandom, $urandom};
      return {dz, hi, lo, c};
   endfunction

   task automatic compare_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic send_sample(astc_req_type item, bit pinned, astc_rsp_type want);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
         if (gap != 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_data  = item;
      pin_valid = pinned;
      pin_rsp   = want;
      req_valid = 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic reg_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = ADDR_W'(idx) << IDX_LSB;
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   always @(negedge clock) begin
      case ((cycles / 350) % 4)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= ((cycles % 7) > 2);
         default: rsp_ready <= ($urandom_range(0, 9) < 3);
      endcase
   end

   always @(posedge clock) begin : monitor
      astc_rsp_type want;
      logic [IDX_W-1:0] idx;
      cycles++;
      if (!reset) begin
         if (psel && penable && pwrite && pready) begin
            idx = paddr[IDX_LSB +: IDX_W];
            case (idx)
               REG_ALPHA: alpha_reg = pwdata[ALPHA_W-1:0];
               REG_CAL0, REG_CAL1, REG_CAL2, REG_CAL3:
                  cal_word[2'(idx - REG_CAL0)] = pwdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            want = filter_and_map(req_data);
            if (pin_valid) want = pin_rsp;
            pending_rsp.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual %p", $time, rsp_data);
               mismatches++;
            end else begin
               want = pending_rsp.pop_front();
               compare_field("out_chan", int'(want.out_chan), int'(rsp_data.out_chan));
               compare_field("level", int'(want.level), int'(rsp_data.level));
               compare_field("stick_pos", int'(want.stick_pos), int'(rsp_data.stick_pos));
               compare_field("pull", int'(want.pull), int'(rsp_data.pull));
               compare_field("dead", int'(want.dead), int'(rsp_data.dead));
            end
         end
      end
      if (cycles == CYCLE_LIMIT) begin
         $display("analog_stick_trigger_conditioner_test: errors");
         $finish;
      end
   end

   initial begin : stimulus
      astc_req_type       item;
      logic [ALPHA_W-1:0] alpha;
      int                 pick;
      directed = '{
         pin(0, 2048, 2048, 0, 0, 1'b1),
         pin(1, 0, 0, 127, 0, 1'b0),
         pin(2, 4095, 4095, 0, 0, 1'b0),
         pin(3, 0, 0, -127, 0, 1'b0),
         smp(2, 0),
         smp(0, 4095),
         smp(1, 4095),
         smp(3, 2048),
         wr(REG_ALPHA, 64'd256),
         pin(0, 0, 0, -127, 0, 1'b0),
         wr(REG_ALPHA, 64'd511),
         pin(2, 0, 0, 0, 255, 1'b0),
         pin(1, 4095, 4095, -126, 0, 1'b0),
         wr(REG_ALPHA, 64'd0),
         smp(3, 4095),
         wr(REG_ALPHA, 64'd256),
         // positive stick range empty
         wr(REG_CAL0, 64'h0000_0FA0_0000_0FA0),
         pin(0, 4095, 4095, 0, 0, 1'b0),
         // deadzone of -1: centre offset goes down the negative path
         wr(REG_CAL3, 64'hFFFF_0FFF_0000_0800),
         pin(3, 2048, 2048, 0, 0, 1'b0),
         smp(3, 2100),
         // trigger range zero, then negative
         wr(REG_CAL2, 64'h0032_07D0_07D0_0000),
         pin(2, 100, 100, 0, 0, 1'b0),
         wr(REG_CAL2, 64'h0000_03E8_0BB8_0000),
         pin(2, 0, 0, 0, 0, 1'b0),
         wr(REG_CAL1, 64'h7FFF_7FFF_8000_8000),
         smp(1, 4095),
         smp(1, 0),
         wr(REG_SPARE_LO, 64'hDEAD_BEEF_0123_4567),
         wr(REG_SPARE_HI, 64'hFFFF_FFFF_FFFF_FFFF),
         smp(0, 2048),
         smp(2, 4095)
      };
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         if (directed[i].is_write) begin
            wait_drained();
            reg_write(directed[i].idx, directed[i].wdata);
         end else begin
            send_sample(directed[i].item, directed[i].pinned, directed[i].want);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         case (phase)
            0: alpha = ALPHA_ONE;
            1: alpha = '0;
            2: alpha = '1;
            3: alpha = 9'd1;
            default: alpha = ALPHA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                                                   : $urandom_range(120, 240));
         endcase
         reg_write(REG_ALPHA, DATA_W'(alpha));
         reg_write(REG_CAL0, random_cal(1'b0));
         reg_write(REG_CAL1, random_cal(1'b0));
         reg_write(REG_CAL2, random_cal(1'b1));
         reg_write(REG_CAL3, random_cal(1'b0));
         repeat (ITEMS_PER_PHASE) begin
            pick = $urandom_range(0, 7);
            item.chan = CHAN_W'($urandom_range(0, 3));
            case (pick)
               0: item.sample = '0;
               1: item.sample = '1;
               default: item.sample = SMP_W'($urandom_range(0, 4095));
            endcase
            send_sample(item, 1'b0, '0);
         end
      end

      req_valid = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (25) @(negedge clock);
      if (mismatches == 0) begin
         $display("analog_stick_trigger_conditioner_test: clean");
      end else begin
         $display("analog_stick_trigger_conditioner_test: errors");
      end
      $finish;
   end

endmodule
